// ===== rtl/absb_pkg.sv =====
// Shared types and constants of the attribute buffer slot binder.
`default_nettype none

package absb_pkg;

	// Widest walk: the location field is five bits, so neither table exceeds 32 entries.
	localparam int WALK_W     = 6;
	localparam int BUF_W      = 16;
	localparam int SLOT_OUT_W = 5;
	localparam logic [SLOT_OUT_W-1:0] SLOT_NONE = 5'h1F;

	typedef enum logic [2:0] {
		ST_BOUND   = 3'd0,
		ST_UNBOUND = 3'd1,
		ST_IGNORED = 3'd2,
		ST_FULL    = 3'd3,
		ST_CLEARED = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_OLD,
		S_SHARE,
		S_RELEASE,
		S_SEARCH,
		S_BIND,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              start;
		logic              en;
		logic [WALK_W-1:0] limit;
	} walk_ctl_t;

	typedef struct packed {
		logic              done;
		logic              run;
		logic              eq;
		logic [WALK_W-1:0] addr;
		logic [WALK_W-1:0] idx;
	} walk_sts_t;

endpackage

`default_nettype wire

// ===== rtl/absb_walk.sv =====
// Table walker: address counter, one compare stage and the shared comparator.
`default_nettype none

module absb_walk
	import absb_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire walk_ctl_t        ctl,
	input  wire logic [BUF_W-1:0] key,
	input  wire logic [BUF_W-1:0] rd_data,
	output walk_sts_t             sts
);

	logic [WALK_W-1:0] cnt_q;
	logic [WALK_W-1:0] idx_s1;
	logic              run_s1;
	logic              issue;

	// An entry is read each cycle up to the limit; its data is compared in the next cycle.
	assign issue = ctl.en && (cnt_q < ctl.limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_s1 <= 1'b0;
		end else if (ctl.start) begin
			cnt_q  <= '0;
			run_s1 <= 1'b0;
		end else begin
			run_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1 <= cnt_q;
		end
	end

	assign sts.done = (cnt_q >= ctl.limit);
	assign sts.run  = run_s1;
	assign sts.eq   = (rd_data == key);
	assign sts.addr = cnt_q;
	assign sts.idx  = idx_s1;

endmodule

`default_nettype wire

// ===== rtl/attribute_buffer_slot_binder.sv =====
// Top level of the attribute buffer slot binder.
`default_nettype none

// Binds attribute locations to a shared table of buffer slots. Each transfer on the input
// stream is one item and gives exactly one result transfer. A clear item or an ignored
// location (negative or not below LOCATIONS) goes straight to the done state. A bind or unbind
// item is handled by a small sequencer around one shared 16-bit comparator: if the location
// was bound, the location table is walked once to see whether another location still uses
// the old buffer, and when a buffer is given the usable slots (slots_in_use capped at SLOTS)
// are walked once to find the slot that already holds it or the lowest free one. The input
// is not ready while an item is in progress. The result sits in an output register, so a new
// item may be taken while the previous result still waits for its consumer. The slot register
// is written over its own channel, which is always ready, and must only be written while the
// block is idle. After reset every location is unbound, every slot is free and slots_in_use
// reads 16.

module attribute_buffer_slot_binder
	import absb_pkg::*;
#(
	parameter int LOCATIONS = 16,
	parameter int SLOTS     = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input items.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // location[4:0], buffer_id[20:5], stream_no[28:21]
	input  wire logic [1:0]  s_tuser,  // operation[0], has_buffer[1]
	// Results.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // slot_index[4:0], slot_released[5], released_slot[9:6]
	output logic [2:0]       m_tuser,  // status[2:0]
	// Slot count register.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [4:0]  cfg_data
);

	localparam int LOC_AW  = (LOCATIONS > 1) ? $clog2(LOCATIONS) : 1;
	localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [WALK_W-1:0] LOC_LIMIT  = WALK_W'(LOCATIONS);
	localparam logic [WALK_W-1:0] SLOT_LIMIT = WALK_W'(SLOTS);

	state_t state_q, state_d;

	// Slot count register.
	logic [4:0]        slots_in_use_q;
	logic [WALK_W-1:0] usable;

	// Item being worked on.
	logic [LOC_AW-1:0] loc_q;
	logic              has_q;
	logic [BUF_W-1:0]  buf_q;

	// Binding tables: valid bits in flops, payload in small memories.
	logic [LOCATIONS-1:0] loc_bound_q;
	logic [SLOTS-1:0]     slot_occ_q;
	logic [BUF_W-1:0]      loc_buf_mem  [LOCATIONS];
	logic [SLOT_OUT_W-1:0] loc_slot_mem [LOCATIONS];
	logic [BUF_W-1:0]      slot_buf_mem [SLOTS];
	logic [BUF_W-1:0]      loc_buf_rd_q;
	logic [SLOT_OUT_W-1:0] loc_slot_rd_q;
	logic [BUF_W-1:0]      slot_buf_rd_q;
	logic [LOC_AW-1:0]     loc_raddr;

	// Release bookkeeping.
	logic                  was_bound_q;
	logic                  shared_q;
	logic [BUF_W-1:0]      old_buf_q;
	logic [SLOT_OUT_W-1:0] old_slot_q;

	// Search results.
	logic               found_v_q;
	logic               free_v_q;
	logic [SLOT_AW-1:0] found_idx_q;
	logic [SLOT_AW-1:0] free_idx_q;
	logic [SLOT_AW-1:0] bind_slot;

	// Result being built and the output register.
	logic [SLOT_OUT_W-1:0] res_slot_q;
	status_t               res_status_q;
	logic                  res_rel_q;
	logic [3:0]            res_rslot_q;
	logic                  out_valid_q;
	logic [SLOT_OUT_W-1:0] out_slot_q;
	status_t               out_status_q;
	logic                  out_rel_q;
	logic [3:0]            out_rslot_q;

	// Decoded input.
	logic [4:0] in_loc;
	logic       in_op;
	logic       in_loc_ok;
	logic       accept;
	logic       out_free;

	// Sequencer controls.
	walk_ctl_t        wctl;
	walk_sts_t        wsts;
	logic [BUF_W-1:0] cmp_key;
	logic [BUF_W-1:0] cmp_data;
	logic             do_clear;
	logic             do_release;
	logic             bind_ok;

	assign in_loc    = s_tdata[4:0];
	assign in_op     = s_tuser[0];
	assign in_loc_ok = !in_loc[4] && ({1'b0, in_loc} < LOC_LIMIT);
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign cfg_ready = 1'b1;

	assign usable = ({1'b0, slots_in_use_q} > SLOT_LIMIT) ? SLOT_LIMIT : {1'b0, slots_in_use_q};

	// The comparator checks the old buffer during the location walk and the new one during
	// the slot walk.
	assign cmp_key  = (state_q == S_SHARE) ? old_buf_q : buf_q;
	assign cmp_data = (state_q == S_SHARE) ? loc_buf_rd_q : slot_buf_rd_q;

	absb_walk u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (wctl),
		.key     (cmp_key),
		.rd_data (cmp_data),
		.sts     (wsts)
	);

	assign do_clear   = accept && in_op;
	// A slot is freed only when no other bound location uses its buffer.
	assign do_release = (state_q == S_RELEASE) && was_bound_q && !shared_q
		&& ({1'b0, old_slot_q} < SLOT_LIMIT);
	assign bind_ok    = (state_q == S_BIND) && (found_v_q || free_v_q);
	assign bind_slot  = found_v_q ? found_idx_q : free_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		wctl.start = 1'b0;
		wctl.en    = 1'b0;
		wctl.limit = '0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = (in_op || !in_loc_ok) ? S_DONE : S_OLD;
				end
			end
			S_OLD: begin
				if (loc_bound_q[loc_q]) begin
					wctl.start = 1'b1;
					state_d    = S_SHARE;
				end else begin
					state_d = S_RELEASE;
				end
			end
			S_SHARE: begin
				wctl.en    = 1'b1;
				wctl.limit = LOC_LIMIT;
				if (wsts.done) begin
					state_d = S_RELEASE;
				end
			end
			S_RELEASE: begin
				if (has_q) begin
					wctl.start = 1'b1;
					state_d    = S_SEARCH;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SEARCH: begin
				wctl.en    = 1'b1;
				wctl.limit = usable;
				if (wsts.done) begin
					state_d = S_BIND;
				end
			end
			S_BIND: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_in_use_q <= 5'd16;
		end else if (cfg_valid && cfg_ready) begin
			slots_in_use_q <= cfg_data;
		end
	end

	// Bound and occupied bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loc_bound_q <= '0;
			slot_occ_q  <= '0;
		end else begin
			if (do_clear) begin
				loc_bound_q <= '0;
				slot_occ_q  <= '0;
			end
			if (state_q == S_OLD) begin
				loc_bound_q[loc_q] <= 1'b0;
			end
			if (do_release) begin
				slot_occ_q[old_slot_q[SLOT_AW-1:0]] <= 1'b0;
			end
			if (bind_ok) begin
				loc_bound_q[loc_q] <= 1'b1;
				if (!found_v_q) begin
					slot_occ_q[bind_slot] <= 1'b1;
				end
			end
		end
	end

	// Location memories are read at the incoming location on acceptance and at the walk
	// address otherwise.
	assign loc_raddr = (state_q == S_IDLE) ? in_loc[LOC_AW-1:0] : wsts.addr[LOC_AW-1:0];

	always_ff @(posedge clk) begin
		if (bind_ok) begin
			loc_buf_mem[loc_q]  <= buf_q;
			loc_slot_mem[loc_q] <= SLOT_OUT_W'(bind_slot);
		end
		loc_buf_rd_q  <= loc_buf_mem[loc_raddr];
		loc_slot_rd_q <= loc_slot_mem[loc_raddr];
	end

	always_ff @(posedge clk) begin
		if (bind_ok && !found_v_q) begin
			slot_buf_mem[bind_slot] <= buf_q;
		end
		slot_buf_rd_q <= slot_buf_mem[wsts.addr[SLOT_AW-1:0]];
	end

	// Item capture and the bookkeeping of both walks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_bound_q <= 1'b0;
			shared_q    <= 1'b0;
			found_v_q   <= 1'b0;
			free_v_q    <= 1'b0;
		end else begin
			if (state_q == S_OLD) begin
				was_bound_q <= loc_bound_q[loc_q];
				shared_q    <= 1'b0;
			end
			if ((state_q == S_SHARE) && wsts.run && wsts.eq
				&& loc_bound_q[wsts.idx[LOC_AW-1:0]]) begin
				shared_q <= 1'b1;
			end
			if (state_q == S_RELEASE) begin
				found_v_q <= 1'b0;
				free_v_q  <= 1'b0;
			end
			if ((state_q == S_SEARCH) && wsts.run && !found_v_q) begin
				if (slot_occ_q[wsts.idx[SLOT_AW-1:0]]) begin
					if (wsts.eq) begin
						found_v_q <= 1'b1;
					end
				end else if (!free_v_q) begin
					free_v_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			loc_q <= in_loc[LOC_AW-1:0];
			has_q <= s_tuser[1];
			buf_q <= s_tdata[20:5];
		end
		if (state_q == S_OLD) begin
			old_buf_q  <= loc_buf_rd_q;
			old_slot_q <= loc_slot_rd_q;
		end
		if ((state_q == S_SEARCH) && wsts.run && !found_v_q) begin
			if (slot_occ_q[wsts.idx[SLOT_AW-1:0]] && wsts.eq) begin
				found_idx_q <= wsts.idx[SLOT_AW-1:0];
			end else if (!slot_occ_q[wsts.idx[SLOT_AW-1:0]] && !free_v_q) begin
				free_idx_q <= wsts.idx[SLOT_AW-1:0];
			end
		end
	end

	// Result assembly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_slot_q   <= SLOT_NONE;
			res_status_q <= ST_IGNORED;
			res_rel_q    <= 1'b0;
			res_rslot_q  <= '0;
		end else begin
			if (accept) begin
				res_slot_q  <= SLOT_NONE;
				res_rel_q   <= 1'b0;
				res_rslot_q <= '0;
				if (in_op) begin
					res_status_q <= ST_CLEARED;
				end else if (!in_loc_ok) begin
					res_status_q <= ST_IGNORED;
				end
			end
			if (do_release) begin
				res_rel_q   <= 1'b1;
				res_rslot_q <= old_slot_q[3:0];
			end
			if ((state_q == S_RELEASE) && !has_q) begin
				res_status_q <= ST_UNBOUND;
			end
			if (state_q == S_BIND) begin
				if (bind_ok) begin
					res_status_q <= ST_BOUND;
					res_slot_q   <= SLOT_OUT_W'(bind_slot);
				end else begin
					res_status_q <= ST_FULL;
				end
			end
		end
	end

	// Output register: loaded once the item is finished and the previous result has gone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			out_slot_q   <= res_slot_q;
			out_status_q <= res_status_q;
			out_rel_q    <= res_rel_q;
			out_rslot_q  <= res_rslot_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_rslot_q, out_rel_q, out_slot_q};
	assign m_tuser  = out_status_q;

	// An accepted item keeps the input closed for at least the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready straight after an accepted item");

	// The location walk only runs for a location that was bound.
	a_share_needs_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHARE) |-> was_bound_q)
		else $error("sharing walk for an unbound location");

	// Only a bound result carries a slot.
	a_slot_none: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q != ST_BOUND)) |-> (out_slot_q == SLOT_NONE))
		else $error("slot reported for a result that is not bound");

	// Clear and ignored items never free a slot.
	a_no_release: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && ((out_status_q == ST_CLEARED) || (out_status_q == ST_IGNORED)))
		|-> !out_rel_q)
		else $error("release reported for a clear or ignored item");

endmodule

`default_nettype wire
